// File: src/mfp_pkg.sv
`timescale 1ns / 1ps
package mfp_pkg;

  localparam logic [7:0]  START_V2    = 8'hFD;
  localparam logic [7:0]  START_V1    = 8'hFE;
  localparam int          HDR_DEPTH   = 9;
  localparam logic [3:0]  HDR_LEN_V2  = 4'd9;
  localparam logic [3:0]  HDR_LEN_V1  = 4'd5;
  localparam logic [7:0]  MAX_PAYLOAD = 8'd255;
  localparam logic [3:0]  SIG_BYTES   = 4'd13;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam logic [23:0] RST_FIRST_ID     = 24'd0;
  localparam logic [7:0]  RST_FIRST_EXTRA  = 8'd50;
  localparam logic [23:0] RST_SECOND_ID    = 24'd253;
  localparam logic [7:0]  RST_SECOND_EXTRA = 8'd83;

  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam logic [QPW-1:0] QPTR_LAST = QPW'(QDEPTH - 1);
  localparam logic [QPW-1:0] QPTR_ONE  = QPW'(1);
  localparam logic [QCW-1:0] QCNT_ONE  = QCW'(1);
  localparam logic [QCW-1:0] QCNT_FULL = QCW'(QDEPTH);

  localparam int TDATA_W = 72;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC1,
    PH_CRC2,
    PH_SIG
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_CRC_MISMATCH = 2'd1,
    ST_UNKNOWN_ID   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_FIRST_ID     = 2'd0,
    CFG_FIRST_EXTRA  = 2'd1,
    CFG_SECOND_ID    = 2'd2,
    CFG_SECOND_EXTRA = 2'd3
  } cfg_idx_e;

  // queue entry: one payload byte or one frame end awaiting its check
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        is_v2;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [23:0] msg_id;
    logic [7:0]  length;
    logic [15:0] run_crc;
    logic [15:0] rx_crc;
  } mfp_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    status_e     status;
    logic        is_v2;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [23:0] msg_id;
    logic [7:0]  length;
  } mfp_result_t;

  // X25 / MCRF4XX, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// File: src/mfp_front.sv
`timescale 1ns / 1ps
module mfp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output mfp_pkg::mfp_item_t item_o
);
  import mfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q [HDR_DEPTH];
  logic        hdr_we;
  logic [3:0]  hpos_q, hpos_d;
  logic        v2_q, v2_d;
  logic        signed_q, signed_d;
  logic [7:0]  flen_q, flen_d;
  logic [7:0]  ppos_q, ppos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [3:0]  sig_q, sig_d;
  logic [3:0]  need;

  assign need = v2_q ? HDR_LEN_V2 : HDR_LEN_V1;

  always_comb begin
    phase_d  = phase_q;
    hpos_d   = hpos_q;
    v2_d     = v2_q;
    signed_d = signed_q;
    flen_d   = flen_q;
    ppos_d   = ppos_q;
    crc_d    = crc_q;
    rcrc_d   = rcrc_q;
    sig_d    = sig_q;
    hdr_we   = 1'b0;
    push_o   = 1'b0;

    if (accept_i) begin
      case (phase_q)
        PH_WAIT: begin
          if (rx_byte_i == START_V2 || rx_byte_i == START_V1) begin
            v2_d    = (rx_byte_i == START_V2);
            hpos_d  = 4'd0;
            crc_d   = CRC_INIT;
            phase_d = PH_HEADER;
          end
        end
        PH_HEADER: begin
          hdr_we = (hpos_q < 4'(HDR_DEPTH));
          crc_d  = crc_step(crc_q, rx_byte_i);
          hpos_d = hpos_q + 4'd1;
          if (hpos_d >= need) begin
            flen_d = hdr_q[0];
            ppos_d = 8'd0;
            if (hdr_q[0] > MAX_PAYLOAD) begin
              phase_d  = PH_WAIT;
              hpos_d   = 4'd0;
              ppos_d   = 8'd0;
              flen_d   = 8'd0;
              sig_d    = 4'd0;
              signed_d = 1'b0;
              v2_d     = 1'b0;
            end else begin
              signed_d = v2_q & hdr_q[1][0];
              phase_d  = (hdr_q[0] != 8'd0) ? PH_PAYLOAD : PH_CRC1;
            end
          end
        end
        PH_PAYLOAD: begin
          push_o = 1'b1;
          crc_d  = crc_step(crc_q, rx_byte_i);
          ppos_d = ppos_q + 8'd1;
          if (ppos_d == flen_q) begin
            phase_d = PH_CRC1;
          end
        end
        PH_CRC1: begin
          rcrc_d  = {8'h00, rx_byte_i};
          phase_d = PH_CRC2;
        end
        PH_CRC2: begin
          rcrc_d = {rx_byte_i, rcrc_q[7:0]};
          if (v2_q && signed_q) begin
            sig_d   = 4'd0;
            phase_d = PH_SIG;
          end else begin
            phase_d = PH_WAIT;
            push_o  = 1'b1;
          end
        end
        PH_SIG: begin
          sig_d = sig_q + 4'd1;
          if (sig_d == SIG_BYTES) begin
            phase_d = PH_WAIT;
            push_o  = 1'b1;
          end
        end
        default: begin
          phase_d  = PH_WAIT;
          hpos_d   = 4'd0;
          ppos_d   = 8'd0;
          flen_d   = 8'd0;
          sig_d    = 4'd0;
          signed_d = 1'b0;
          v2_d     = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    item_o = '0;
    if (phase_q == PH_PAYLOAD) begin
      item_o.kind       = KIND_PAYLOAD;
      item_o.data_byte  = rx_byte_i;
      item_o.byte_index = ppos_q;
    end else begin
      item_o.kind    = KIND_REPORT;
      item_o.is_v2   = v2_q;
      item_o.length  = flen_q;
      item_o.run_crc = crc_q;
      item_o.rx_crc  = rcrc_d;
      if (v2_q) begin
        item_o.sys_id  = hdr_q[4];
        item_o.comp_id = hdr_q[5];
        item_o.msg_id  = {hdr_q[8], hdr_q[7], hdr_q[6]};
      end else begin
        item_o.sys_id  = hdr_q[2];
        item_o.comp_id = hdr_q[3];
        item_o.msg_id  = {16'h0000, hdr_q[4]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      hpos_q   <= 4'd0;
      v2_q     <= 1'b0;
      signed_q <= 1'b0;
      flen_q   <= 8'd0;
      ppos_q   <= 8'd0;
      crc_q    <= CRC_INIT;
      rcrc_q   <= 16'h0000;
      sig_q    <= 4'd0;
    end else begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      v2_q     <= v2_d;
      signed_q <= signed_d;
      flen_q   <= flen_d;
      ppos_q   <= ppos_d;
      crc_q    <= crc_d;
      rcrc_q   <= rcrc_d;
      sig_q    <= sig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hpos_q] <= rx_byte_i;
    end
  end

endmodule

// File: src/mfp_queue.sv
`timescale 1ns / 1ps
module mfp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mfp_pkg::mfp_item_t push_item_i,
  input  logic               pop_i,
  output mfp_pkg::mfp_item_t head_o,
  output logic               empty_o,
  output logic               full_o
);
  import mfp_pkg::*;

  mfp_item_t       mem_q [QDEPTH];
  logic [QPW-1:0]  wptr_q, wptr_d;
  logic [QPW-1:0]  rptr_q, rptr_d;
  logic [QCW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_FULL);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_LAST) ? '0 : wptr_q + QPTR_ONE;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_LAST) ? '0 : rptr_q + QPTR_ONE;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_ONE;
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_FULL) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + QCNT_ONE)
    else $error("queue count did not advance");
`endif

endmodule

// File: src/mfp_back.sv
`timescale 1ns / 1ps
module mfp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  input  mfp_pkg::mfp_item_t   head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mfp_pkg::mfp_result_t out_o
);
  import mfp_pkg::*;

  logic [23:0] first_id_q;
  logic [7:0]  first_extra_q;
  logic [23:0] second_id_q;
  logic [7:0]  second_extra_q;
  logic        valid_q, valid_d;
  mfp_result_t res_q, res_d;
  logic        known;
  logic [7:0]  extra;

  always_comb begin
    known = 1'b1;
    extra = first_extra_q;
    if (head_i.msg_id == first_id_q) begin
      extra = first_extra_q;
    end else if (head_i.msg_id == second_id_q) begin
      extra = second_extra_q;
    end else begin
      known = 1'b0;
    end
  end

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (pop_o) begin
      valid_d          = 1'b1;
      res_d.kind       = head_i.kind;
      res_d.data_byte  = head_i.data_byte;
      res_d.byte_index = head_i.byte_index;
      res_d.is_v2      = head_i.is_v2;
      res_d.sys_id     = head_i.sys_id;
      res_d.comp_id    = head_i.comp_id;
      res_d.msg_id     = head_i.msg_id;
      res_d.length     = head_i.length;
      if (head_i.kind == KIND_PAYLOAD) begin
        res_d.status = ST_ACCEPTED;
      end else if (!known) begin
        res_d.status = ST_UNKNOWN_ID;
      end else if (crc_step(head_i.run_crc, extra) == head_i.rx_crc) begin
        res_d.status = ST_ACCEPTED;
      end else begin
        res_d.status = ST_CRC_MISMATCH;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= 1'b0;
      first_id_q     <= RST_FIRST_ID;
      first_extra_q  <= RST_FIRST_EXTRA;
      second_id_q    <= RST_SECOND_ID;
      second_extra_q <= RST_SECOND_EXTRA;
    end else begin
      valid_q <= valid_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST_ID:     first_id_q     <= cfg_data_i;
          CFG_FIRST_EXTRA:  first_extra_q  <= cfg_data_i[7:0];
          CFG_SECOND_ID:    second_id_q    <= cfg_data_i;
          CFG_SECOND_EXTRA: second_extra_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// File: src/mavlink_frame_parser.sv
`timescale 1ns / 1ps
// MAVLink v1/v2 frame parser.
// s_axis: one received serial byte per transfer (tdata[7:0]).
// m_axis: one item per payload byte and one report per frame end;
//   tuser = item kind (0 payload byte, 1 frame end report).
// cfg: register writes (index 0..3: first id, first crc extra, second id,
//   second crc extra); always ready; to be written by the user only while
//   the block is idle, which the block itself does not enforce.
// Throughput: one byte per cycle while the queue is not full. A parser
// front end feeds a two-entry queue; the back end checks message id and
// CRC extra byte and holds the result in an output register. m_axis
// tvalid rises for an item once it reaches the output register.
// When the receiver stalls, the queue and output register fill and s_axis
// tready drops; nothing is lost. Payload bytes of a frame must be buffered
// by the consumer until the report gives the frame status.
// Reset: parser hunts for a start byte, queue and output are empty, the
// id registers take their defaults. No clearing pass is needed.
module mavlink_frame_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] data_byte, [15:8] byte_index, [17:16] frame_status,
  // [18] is_version_two, [26:19] sys_id, [34:27] comp_id,
  // [58:35] msg_id, [66:59] payload_length, [71:67] zero
  output logic [mfp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,   // [0] item_kind
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [23:0]                 cfg_data_i
);
  import mfp_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  mfp_item_t   push_item;
  mfp_item_t   head;
  mfp_result_t res;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  mfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .push_o    (push),
    .item_o    (push_item)
  );

  mfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  mfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {5'b00000, res.length, res.msg_id, res.comp_id, res.sys_id,
                         res.is_v2, res.status, res.byte_index, res.data_byte};

endmodule
